// ===== sv/cht_pkg.sv =====
// ============================================================================
// cht_pkg: shared types and constants for the chained hash table
// Operation and status codes, hashing constant and the item that walks the
// row of storage cells.
// ============================================================================
package cht_pkg;

    // key and count widths
    localparam int KEY_W = 31;
    localparam int CNT_W = 5;
    localparam int BKT_W = 4;

    // default number of storage cells
    localparam int MAX_SLOTS_DEF = 16;

    // table size after reset (clamped to the cell count at the top level)
    localparam int TS_RESET = 10;

    // 0.6180339887 in 0.32 fixed point
    localparam logic [31:0] PHI_FRAC = 32'h9E37_79B9;

    // operation codes
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;
    localparam logic [1:0] MODE_SEARCH = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    // item passed from cell to cell
    typedef struct packed {
        logic             vld;
        logic [1:0]       mode;
        logic [KEY_W-1:0] key;
        logic [BKT_W-1:0] bucket;
        logic             ins_en;   // insert allowed (table not full)
        logic             placed;   // insert already written to a cell
        logic             found;    // a matching entry was seen
        logic [CNT_W-1:0] removed;  // copies cleared so far
    } tok_t;

endpackage

// ===== sv/cht_cell.sv =====
// ============================================================================
// cht_cell: one storage entry of the hash table
// Holds a key, its bucket and a valid bit. The passing item is checked and
// updated against the entry and handed to the next cell in the following cycle.
// ============================================================================
module cht_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  cht_pkg::tok_t tok_in,
    output cht_pkg::tok_t tok_out
);

    logic                         valid_reg;
    logic                         valid_next;
    logic [cht_pkg::KEY_W-1:0]    key_reg;
    logic [cht_pkg::BKT_W-1:0]    bucket_reg;
    logic                         wr_en;
    logic                         match;
    cht_pkg::tok_t                tok_reg;
    cht_pkg::tok_t                tok_next;

    // entry match for delete and search
    assign match = valid_reg && (key_reg == tok_in.key) && (bucket_reg == tok_in.bucket);

    // first free cell takes the insert
    assign wr_en = tok_in.vld && (tok_in.mode == cht_pkg::MODE_INSERT) &&
                   tok_in.ins_en && !tok_in.placed && !valid_reg;

    // entry and item update
    always_comb
    begin
        valid_next = valid_reg;
        tok_next   = tok_in;
        if (wr_en)
        begin
            valid_next      = 1'b1;
            tok_next.placed = 1'b1;
        end
        if (tok_in.vld && match &&
            (tok_in.mode == cht_pkg::MODE_DELETE || tok_in.mode == cht_pkg::MODE_SEARCH))
        begin
            tok_next.found = 1'b1;
            if (tok_in.mode == cht_pkg::MODE_DELETE)
            begin
                valid_next       = 1'b0;
                tok_next.removed = tok_in.removed + 1'b1;
            end
        end
    end

    // control state and passing item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    // stored entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_reg    <= tok_in.key;
            bucket_reg <= tok_in.bucket;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== sv/chained_hash_table.sv =====
// ============================================================================
// chained_hash_table: hash table with separate chaining over a cell row
// Fibonacci hashing into table_size buckets, entries kept in a row of cells.
// ============================================================================
// Usage:
//   Command port: an item (mode, key) is taken at a clock edge where start is
//   high and busy is low. busy stays high until the result is shown.
//   Result port: status, bucket and occupancy are valid for exactly one cycle
//   while done is high. There is no back-pressure; the receiver must take it.
//   Config port: cfg_we writes cfg_wdata to table_size at the clock edge. The
//   write is dropped while the table holds any key; the value is clamped to
//   1..min(16, MAX_SLOTS). Write only while busy is low.
//   Timing: the hash registers key times the golden-ratio fraction, then the
//   fraction times table_size; then the item walks the row of MAX_SLOTS
//   cells, one cell a cycle, and the result is registered. A new item is
//   taken only once the result of the last one is shown, so the length of
//   the cell row sets how often items are handled.
//   Reset: all entries invalid, count zero, table_size back to its default,
//   busy low. No clearing pass is needed.
// ============================================================================
module chained_hash_table #(
    parameter int MAX_SLOTS = cht_pkg::MAX_SLOTS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                mode,
    input  logic [cht_pkg::KEY_W-1:0] key,
    input  logic                      cfg_we,
    input  logic [cht_pkg::CNT_W-1:0] cfg_wdata,
    output logic                      done,
    output logic [1:0]                status,
    output logic [cht_pkg::BKT_W-1:0] bucket,
    output logic [cht_pkg::CNT_W-1:0] occupancy
);

    localparam logic [cht_pkg::CNT_W-1:0] TS_LIMIT =
        cht_pkg::CNT_W'((MAX_SLOTS < 16) ? MAX_SLOTS : 16);
    localparam logic [cht_pkg::CNT_W-1:0] TS_INIT =
        (cht_pkg::CNT_W'(cht_pkg::TS_RESET) > TS_LIMIT) ? TS_LIMIT :
        cht_pkg::CNT_W'(cht_pkg::TS_RESET);

    logic                      accept;
    logic                      busy_reg;
    logic                      busy_next;
    logic [cht_pkg::CNT_W-1:0] ts_reg;
    logic [cht_pkg::CNT_W-1:0] ts_next;
    logic [cht_pkg::CNT_W-1:0] count_reg;
    logic [cht_pkg::CNT_W-1:0] count_next;

    logic                      s1_vld_reg;
    logic [1:0]                s1_mode_reg;
    logic [cht_pkg::KEY_W-1:0] s1_key_reg;
    logic                      s1_ins_en_reg;
    logic [31:0]               frac_reg;
    logic [31:0]               frac_next;
    logic [35:0]               scaled;

    cht_pkg::tok_t             head_reg;
    cht_pkg::tok_t             head_next;
    cht_pkg::tok_t             tok_chain [0:MAX_SLOTS];
    cht_pkg::tok_t             tail;

    logic                      done_reg;
    logic [1:0]                status_reg;
    logic [1:0]                status_next;
    logic [cht_pkg::BKT_W-1:0] bucket_reg;

    assign accept = start && !busy_reg;

    // hash step one: fractional part of key times the golden ratio
    assign frac_next = {1'b0, key} * cht_pkg::PHI_FRAC;

    // hash step two: scale the fraction to the bucket range
    assign scaled = 36'(frac_reg) * 36'(ts_reg);

    always_comb
    begin
        head_next         = '0;
        head_next.vld     = s1_vld_reg;
        head_next.mode    = s1_mode_reg;
        head_next.key     = s1_key_reg;
        head_next.bucket  = scaled[35:32];
        head_next.ins_en  = s1_ins_en_reg;
    end

    // row of storage cells
    assign tok_chain[0] = head_reg;
    generate
        for (genvar i = 0; i < MAX_SLOTS; i++)
        begin : g_cell
            cht_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .tok_in  (tok_chain[i]),
                .tok_out (tok_chain[i+1])
            );
        end
    endgenerate
    assign tail = tok_chain[MAX_SLOTS];

    // result and count from the item leaving the row
    always_comb
    begin
        status_next = cht_pkg::ST_NOTFOUND;
        count_next  = count_reg;
        if (tail.vld)
        begin
            case (tail.mode)
                cht_pkg::MODE_INSERT:
                begin
                    if (!tail.ins_en)
                    begin
                        status_next = cht_pkg::ST_FULL;
                    end
                    else if (tail.placed)
                    begin
                        status_next = cht_pkg::ST_OK;
                        count_next  = count_reg + 1'b1;
                    end
                end
                cht_pkg::MODE_DELETE:
                begin
                    if (tail.found)
                    begin
                        status_next = cht_pkg::ST_OK;
                        count_next  = (tail.removed > count_reg) ? '0 :
                                      count_reg - tail.removed;
                    end
                end
                cht_pkg::MODE_SEARCH:
                begin
                    if (tail.found)
                    begin
                        status_next = cht_pkg::ST_OK;
                    end
                end
                default:
                begin
                    status_next = cht_pkg::ST_NOTFOUND;
                end
            endcase
        end
    end

    // busy from accept until the result is registered
    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (tail.vld)
        begin
            busy_next = 1'b0;
        end
    end

    // table size write, only while empty, clamped
    always_comb
    begin
        ts_next = ts_reg;
        if (cfg_we && count_reg == '0)
        begin
            if (cfg_wdata == '0)
            begin
                ts_next = cht_pkg::CNT_W'(1);
            end
            else if (cfg_wdata > TS_LIMIT)
            begin
                ts_next = TS_LIMIT;
            end
            else
            begin
                ts_next = cfg_wdata;
            end
        end
    end

    // control state and head of the row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            ts_reg     <= TS_INIT;
            count_reg  <= '0;
            s1_vld_reg <= 1'b0;
            head_reg   <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            ts_reg     <= ts_next;
            count_reg  <= count_next;
            s1_vld_reg <= accept;
            head_reg   <= head_next;
            done_reg   <= tail.vld;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mode_reg   <= mode;
            s1_key_reg    <= key;
            s1_ins_en_reg <= (count_reg < ts_reg);
            frac_reg      <= frac_next;
        end
        if (tail.vld)
        begin
            status_reg <= status_next;
            bucket_reg <= tail.bucket;
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign status    = status_reg;
    assign bucket    = bucket_reg;
    assign occupancy = count_reg;

    // checks
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a pending item");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ts_reg)
        else $error("stored count above table size");

endmodule
